// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared widths, operation and status codes, cell command types and the
// priority clamp used by the queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Field widths of the request and response transactions.
  localparam int ACTION_W = 2;
  localparam int TASK_ID_W = 16;
  localparam int PRIO_W = 4;
  localparam int STATUS_W = 3;
  localparam int OCC_W = 5;

  // Default configuration.
  localparam int DEPTH_DEFAULT = 16;
  localparam int ID_BITS_DEFAULT = 16;

  // Priority range.
  localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;

  // Request operations.
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STS_OK = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] STS_DUP = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;

  typedef logic [PRIO_W-1:0] prio_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // What every cell does in the update cycle.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE
  } cmd_e;

  // Control group broadcast from the controller to the cell row.
  typedef struct packed {
    logic load_flags;
    cmd_e cmd;
  } spq_ctrl_t;

  // Out-of-range priorities are pulled into the legal range.
  function automatic prio_t prio_clamp(prio_t p);
    prio_t r;
    r = p;
    if (p < PRIO_MIN) begin
      r = PRIO_MIN;
    end else if (p > PRIO_MAX) begin
      r = PRIO_MAX;
    end
    return r;
  endfunction

endpackage

// File: sv/spq_if.sv
// ----------------------------------------------------------------------------
// Stable priority queue channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::ACTION_W-1:0]  action;
  logic [spq_pkg::TASK_ID_W-1:0] task_id;
  logic [spq_pkg::PRIO_W-1:0]    task_priority;

  modport source(output valid, action, task_id, task_priority, input ready);
  modport sink(input valid, action, task_id, task_priority, output ready);
endinterface

interface spq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [spq_pkg::TASK_ID_W-1:0] out_id;
  logic [spq_pkg::PRIO_W-1:0]    out_priority;
  logic [spq_pkg::OCC_W-1:0]     occupancy;

  modport source(output valid, status, out_id, out_priority, occupancy, input ready);
  modport sink(input valid, status, out_id, out_priority, occupancy, output ready);
endinterface

// File: sv/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded task queue kept sorted by priority, stable among equal priorities.
// ----------------------------------------------------------------------------
// Each request transaction runs from acceptance to a registered response:
// in the accept cycle every cell compares its slot with the request ID and
// priority and stores the result, and in the following cycle the
// controller decides the outcome and the whole row shifts by one place at
// once (toward the back on insert, toward the front on pop or remove). One
// request is in flight at a time; the next one is taken as soon as the
// response register is free or is being drained in that cycle. The queue
// holds DEPTH entries; the ID is stored and compared in its low ID_BITS bits.
// Slot contents are not cleared by reset; the entry count, state, response
// valid and cell flags are.
module stable_priority_queue #(
  parameter int DEPTH   = spq_pkg::DEPTH_DEFAULT,
  parameter int ID_BITS = spq_pkg::ID_BITS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Row of cells and the wiring between neighbors.
  logic [ID_BITS-1:0] cell_id    [DEPTH];
  spq_pkg::prio_t     cell_prio  [DEPTH];
  logic [DEPTH-1:0]   cell_lt;
  logic [DEPTH-1:0]   cell_match;
  logic [DEPTH:0]     past;

  spq_pkg::state_e    state_q, state_d;
  spq_pkg::spq_ctrl_t ctrl;
  logic [CNT_W-1:0]   count_q, count_d;

  // The request as it is held through the update cycle.
  logic [spq_pkg::ACTION_W-1:0] op_q;
  logic [ID_BITS-1:0]           id_q;
  spq_pkg::prio_t               prio_q;

  logic [ID_BITS-1:0] key_id;
  spq_pkg::prio_t     key_prio;
  logic               accept;
  logic               any_match;
  logic [ID_BITS-1:0] hit_id;
  spq_pkg::prio_t     hit_prio;

  // Response register.
  logic                          rsp_valid_q;
  logic [spq_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [spq_pkg::TASK_ID_W-1:0] out_id_q, out_id_d;
  spq_pkg::prio_t                out_prio_q, out_prio_d;
  logic [spq_pkg::OCC_W-1:0]     occ_q;

  assign key_id   = ID_BITS'(req_i.task_id);
  assign key_prio = spq_pkg::prio_clamp(req_i.task_priority);

  // A pop deletes from the front, so the delete wave starts already set.
  assign past[0] = (op_q == spq_pkg::ACT_POP);

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ID_BITS-1:0] l_id, r_id;
    spq_pkg::prio_t     l_prio, r_prio;
    logic               l_lt;

    if (g == 0) begin : g_first
      assign l_id   = '0;
      assign l_prio = '0;
      assign l_lt   = 1'b0;
    end else begin : g_mid
      assign l_id   = cell_id[g-1];
      assign l_prio = cell_prio[g-1];
      assign l_lt   = cell_lt[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign r_id   = '0;
      assign r_prio = '0;
    end else begin : g_inner
      assign r_id   = cell_id[g+1];
      assign r_prio = cell_prio[g+1];
    end

    spq_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .live_i      (CNT_W'(g) < count_q),
      .key_id_i    (key_id),
      .key_prio_i  (key_prio),
      .new_id_i    (id_q),
      .new_prio_i  (prio_q),
      .left_id_i   (l_id),
      .left_prio_i (l_prio),
      .left_lt_i   (l_lt),
      .right_id_i  (r_id),
      .right_prio_i(r_prio),
      .past_i      (past[g]),
      .id_o        (cell_id[g]),
      .prio_o      (cell_prio[g]),
      .lt_o        (cell_lt[g]),
      .match_o     (cell_match[g]),
      .past_o      (past[g+1])
    );
  end

  assign any_match = |cell_match;

  // IDs are unique in the queue, so at most one match flag is set.
  always_comb begin
    hit_id   = '0;
    hit_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_id   = hit_id | (cell_match[i] ? cell_id[i] : '0);
      hit_prio = hit_prio | (cell_match[i] ? cell_prio[i] : '0);
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        state_d = spq_pkg::ST_IDLE;
      end
      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // Output logic: handshake, cell commands and the response contents.
  always_comb begin
    req_i.ready     = 1'b0;
    ctrl.load_flags = 1'b0;
    ctrl.cmd        = spq_pkg::CMD_HOLD;
    count_d         = count_q;
    status_d        = spq_pkg::STS_OK;
    out_id_d        = '0;
    out_prio_d      = '0;
    unique case (state_q)
      spq_pkg::ST_IDLE: begin
        req_i.ready     = !rsp_valid_q || rsp_o.ready;
        ctrl.load_flags = req_i.valid && req_i.ready;
      end
      spq_pkg::ST_EXEC: begin
        unique case (op_q)
          spq_pkg::ACT_INSERT: begin
            if (any_match) begin
              status_d = spq_pkg::STS_DUP;
            end else if (count_q == CNT_W'(DEPTH)) begin
              status_d = spq_pkg::STS_FULL;
            end else begin
              ctrl.cmd = spq_pkg::CMD_INSERT;
              count_d  = count_q + 1'b1;
            end
          end
          spq_pkg::ACT_POP: begin
            if (count_q == '0) begin
              status_d = spq_pkg::STS_EMPTY;
            end else begin
              ctrl.cmd   = spq_pkg::CMD_DELETE;
              count_d    = count_q - 1'b1;
              out_id_d   = spq_pkg::TASK_ID_W'(cell_id[0]);
              out_prio_d = cell_prio[0];
            end
          end
          spq_pkg::ACT_REMOVE: begin
            if (count_q == '0) begin
              status_d = spq_pkg::STS_EMPTY;
            end else if (!any_match) begin
              status_d = spq_pkg::STS_NOTFOUND;
            end else begin
              ctrl.cmd   = spq_pkg::CMD_DELETE;
              count_d    = count_q - 1'b1;
              out_id_d   = spq_pkg::TASK_ID_W'(hit_id);
              out_prio_d = hit_prio;
            end
          end
          default: begin
            // Unused operation code: nothing changes, status OK.
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign accept = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == spq_pkg::ST_EXEC) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.action;
      id_q   <= key_id;
      prio_q <= key_prio;
    end
    if (state_q == spq_pkg::ST_EXEC) begin
      status_q   <= status_d;
      out_id_q   <= out_id_d;
      out_prio_q <= out_prio_d;
      occ_q      <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_id       = out_id_q;
  assign rsp_o.out_priority = out_prio_q;
  assign rsp_o.occupancy    = occ_q;

`ifndef NO_ASSERTIONS
  // The entry count never goes past the number of cells.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds queue depth");

  // An accepted request is always worked on in the next cycle.
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == spq_pkg::ST_EXEC)
    else $error("accepted request did not enter the update cycle");

  // A response only appears right after an update cycle.
  a_rsp_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == spq_pkg::ST_EXEC))
    else $error("response raised without an update cycle");

  // IDs in the queue are unique, so no two cells match the same request.
  a_match_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == spq_pkg::ST_EXEC |-> $onehot0(cell_match))
    else $error("more than one cell holds the requested ID");

  // A pop on an empty queue reports empty.
  a_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spq_pkg::ST_EXEC && op_q == spq_pkg::ACT_POP && count_q == '0)
    |=> rsp_o.status == spq_pkg::STS_EMPTY)
    else $error("pop on empty queue did not report empty");
`endif

endmodule

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// Holds one queue slot, compares it against the incoming request and shifts
// toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int ID_BITS = spq_pkg::ID_BITS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  logic               live_i,
  input  logic [ID_BITS-1:0] key_id_i,
  input  spq_pkg::prio_t     key_prio_i,
  input  logic [ID_BITS-1:0] new_id_i,
  input  spq_pkg::prio_t     new_prio_i,
  input  logic [ID_BITS-1:0] left_id_i,
  input  spq_pkg::prio_t     left_prio_i,
  input  logic               left_lt_i,
  input  logic [ID_BITS-1:0] right_id_i,
  input  spq_pkg::prio_t     right_prio_i,
  input  logic               past_i,
  output logic [ID_BITS-1:0] id_o,
  output spq_pkg::prio_t     prio_o,
  output logic               lt_o,
  output logic               match_o,
  output logic               past_o
);

  logic [ID_BITS-1:0] id_q, id_d;
  spq_pkg::prio_t     prio_q, prio_d;
  logic               match_q, lt_q;

  // Flags are taken when the request is accepted. A slot that is not in use
  // never matches and counts as lower priority than any new entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      lt_q    <= 1'b1;
    end else if (ctrl_i.load_flags) begin
      match_q <= live_i && (id_q == key_id_i);
      lt_q    <= !(live_i && (prio_q >= key_prio_i));
    end
  end

  always_comb begin
    id_d   = id_q;
    prio_d = prio_q;
    unique case (ctrl_i.cmd)
      spq_pkg::CMD_INSERT: begin
        if (left_lt_i) begin
          id_d   = left_id_i;
          prio_d = left_prio_i;
        end else if (lt_q) begin
          id_d   = new_id_i;
          prio_d = new_prio_i;
        end
      end
      spq_pkg::CMD_DELETE: begin
        if (past_i || match_q) begin
          id_d   = right_id_i;
          prio_d = right_prio_i;
        end
      end
      spq_pkg::CMD_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    prio_q <= prio_d;
  end

  assign id_o    = id_q;
  assign prio_o  = prio_q;
  assign lt_o    = lt_q;
  assign match_o = match_q;
  assign past_o  = past_i || match_q;

endmodule
